/* rtl/accumulator_machine_step_core_defines.svh */
// Assertion macros shared by the accumulator machine RTL.
`ifndef ACCUMULATOR_MACHINE_STEP_CORE_DEFINES_SVH
`define ACCUMULATOR_MACHINE_STEP_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every clock edge out of reset.
`define AMS_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");
// Delayed implication: the consequent must hold after the antecedent.
`define AMS_ASSERT_LAT3(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##3 (cons)) \
    else $error("latency check failed");
`else
`define AMS_ASSERT_IMPLIES(lbl, ante, cons)
`define AMS_ASSERT_LAT3(lbl, ante, cons)
`endif

`endif

/* rtl/ams_pkg.sv */
// Types and constants of the accumulator machine.
package ams_pkg;

  localparam int WORD_W     = 32;
  localparam int ADDR_W     = 8;
  localparam int CNT_W      = 9;
  localparam int DATA_WORDS = 256;
  localparam int PROG_WORDS = 256;
  localparam int DATA_AW    = $clog2(DATA_WORDS);
  localparam int PROG_AW    = $clog2(PROG_WORDS);

  typedef enum logic [1:0] {
    ACT_DATA  = 2'd0,
    ACT_INSTR = 2'd1,
    ACT_STEP  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  // opcodes; the two top codes are no-ops
  localparam logic [2:0] OP_LDR = 3'd0;
  localparam logic [2:0] OP_ADD = 3'd1;
  localparam logic [2:0] OP_INC = 3'd2;
  localparam logic [2:0] OP_DEC = 3'd3;
  localparam logic [2:0] OP_STR = 3'd4;
  localparam logic [2:0] OP_SHW = 3'd5;

  typedef struct packed {
    logic [1:0]               action;
    logic [ADDR_W-1:0]        slot;
    logic [2:0]               opcode;
    logic [ADDR_W-1:0]        addr_a;
    logic [ADDR_W-1:0]        addr_b;
    logic [ADDR_W-1:0]        addr_c;
    logic                     use_b;
    logic                     use_c;
    logic                     show_acc;
    logic signed [WORD_W-1:0] data_value;
  } in_item_t;

  typedef struct packed {
    logic                     shown;
    logic signed [WORD_W-1:0] shown_value;
    logic signed [WORD_W-1:0] accumulator_value;
    logic [CNT_W-1:0]         program_counter;
    logic                     step_taken;
  } out_item_t;

  // one instruction slot as stored
  typedef struct packed {
    logic [2:0]        opcode;
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
    logic [ADDR_W-1:0] addr_c;
    logic              use_b;
    logic              use_c;
    logic              show_acc;
  } instr_t;

  localparam int INSTR_W = $bits(instr_t);

  // fetch stage to execute stage
  typedef struct packed {
    logic              valid;
    action_t           action;
    logic              step;
    instr_t            instr;
    logic [ADDR_W-1:0] wr_addr;
    logic [WORD_W-1:0] wr_value;
    logic [CNT_W-1:0]  counter;
  } exec_ctl_t;

endpackage

/* rtl/ams_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module ams_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/ams_fetch.sv */
// Fetch stage: request register, program counter and instruction store.
module ams_fetch import ams_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  in_item_t         request,
  input  logic [CNT_W-1:0] prog_len,
  output exec_ctl_t        ctl
);

  logic             s1_valid;
  in_item_t         s1_item;
  logic [CNT_W-1:0] counter;
  logic [CNT_W-1:0] counter_next;
  logic             step;
  logic             iwe;
  logic [PROG_AW-1:0] iwaddr;
  logic [PROG_AW-1:0] iraddr;
  instr_t           iwdata;
  logic [INSTR_W-1:0] irdata;
  logic             byp_hit;
  instr_t           byp_instr;
  instr_t           cur_instr;

  // request register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= request;
    end
  end

  // step decision and counter
  assign step = s1_valid && (action_t'(s1_item.action) == ACT_STEP) && (counter < prog_len);
  assign counter_next = step ? counter + CNT_W'(1) : counter;

  always_ff @(posedge clk) begin
    if (rst) begin
      counter <= '0;
    end else begin
      counter <= counter_next;
    end
  end

  // instruction store; the slot for the next counter is prefetched
  assign iwe    = s1_valid && (action_t'(s1_item.action) == ACT_INSTR);
  assign iwaddr = s1_item.slot[PROG_AW-1:0];
  assign iraddr = counter_next[PROG_AW-1:0];
  assign iwdata = '{opcode:   s1_item.opcode,
                    addr_a:   s1_item.addr_a,
                    addr_b:   s1_item.addr_b,
                    addr_c:   s1_item.addr_c,
                    use_b:    s1_item.use_b,
                    use_c:    s1_item.use_c,
                    show_acc: s1_item.show_acc};

  ams_ram #(.WIDTH(INSTR_W), .DEPTH(PROG_WORDS)) u_iram (
    .clk   (clk),
    .we    (iwe),
    .waddr (iwaddr),
    .wdata (iwdata),
    .raddr (iraddr),
    .rdata (irdata)
  );

  // bypass a slot written in the same cycle it was prefetched
  always_ff @(posedge clk) begin
    if (rst) begin
      byp_hit <= 1'b0;
    end else begin
      byp_hit <= iwe && (iwaddr == iraddr);
    end
  end

  always_ff @(posedge clk) begin
    byp_instr <= iwdata;
  end

  assign cur_instr = byp_hit ? byp_instr : instr_t'(irdata);

  // hand-off to execute
  assign ctl = '{valid:    s1_valid,
                 action:   action_t'(s1_item.action),
                 step:     step,
                 instr:    cur_instr,
                 wr_addr:  s1_item.addr_a,
                 wr_value: s1_item.data_value,
                 counter:  counter_next};

endmodule

/* rtl/ams_exec.sv */
// Execute stage: data store, accumulator and result register.
module ams_exec import ams_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  exec_ctl_t ctl,
  output logic      done,
  output out_item_t result
);

  exec_ctl_t          s2;
  logic               s2_valid;
  logic [WORD_W-1:0]  acc;
  logic [WORD_W-1:0]  acc_next;
  logic [DATA_WORDS-1:0] valid;
  logic [DATA_AW-1:0] raddr_a;
  logic [DATA_AW-1:0] raddr_b;
  logic [WORD_W-1:0]  q_a;
  logic [WORD_W-1:0]  q_b;
  logic               vld_a;
  logic               vld_b;
  logic               fwd_a;
  logic               fwd_b;
  logic [WORD_W-1:0]  fwd_data;
  logic               wen;
  logic [DATA_AW-1:0] waddr;
  logic [WORD_W-1:0]  wdata;
  logic [WORD_W-1:0]  ma;
  logic [WORD_W-1:0]  mb;
  logic [WORD_W-1:0]  sum_a;
  logic [WORD_W-1:0]  sum_ab;
  logic               shown;
  logic [WORD_W-1:0]  shown_value;

  // operand reads issued from the fetched instruction
  assign raddr_a = ctl.instr.addr_a[DATA_AW-1:0];
  assign raddr_b = ctl.instr.addr_b[DATA_AW-1:0];

  // two copies give two read ports, both written alike
  ams_ram #(.WIDTH(WORD_W), .DEPTH(DATA_WORDS)) u_dram_a (
    .clk   (clk),
    .we    (wen),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr_a),
    .rdata (q_a)
  );

  ams_ram #(.WIDTH(WORD_W), .DEPTH(DATA_WORDS)) u_dram_b (
    .clk   (clk),
    .we    (wen),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr_b),
    .rdata (q_b)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      done     <= 1'b0;
      acc      <= '0;
      valid    <= '0;
      fwd_a    <= 1'b0;
      fwd_b    <= 1'b0;
    end else begin
      s2_valid <= ctl.valid;
      done     <= s2_valid;
      acc      <= acc_next;
      if (wen) begin
        valid[waddr] <= 1'b1;
      end
      fwd_a <= wen && (waddr == raddr_a);
      fwd_b <= wen && (waddr == raddr_b);
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    s2       <= ctl;
    vld_a    <= valid[raddr_a];
    vld_b    <= valid[raddr_b];
    fwd_data <= wdata;
    result   <= '{shown:             shown,
                  shown_value:       shown_value,
                  accumulator_value: acc_next,
                  program_counter:   s2.counter,
                  step_taken:        s2.step};
  end

  // operands: forwarded write, else stored word, else cleared word
  assign ma = fwd_a ? fwd_data : (vld_a ? q_a : '0);
  assign mb = fwd_b ? fwd_data : (vld_b ? q_b : '0);
  assign sum_a  = acc + ma;
  assign sum_ab = sum_a + mb;

  // instruction execute and store write
  always_comb begin
    acc_next    = acc;
    wen         = 1'b0;
    waddr       = s2.instr.addr_a[DATA_AW-1:0];
    wdata       = acc;
    shown       = 1'b0;
    shown_value = '0;
    case (s2.action)
      ACT_DATA: begin
        wen   = s2_valid;
        waddr = s2.wr_addr[DATA_AW-1:0];
        wdata = s2.wr_value;
      end
      ACT_STEP: begin
        if (s2_valid && s2.step) begin
          case (s2.instr.opcode)
            OP_LDR: begin
              acc_next = ma;
            end
            OP_ADD: begin
              if (!s2.instr.use_b && !s2.instr.use_c) begin
                acc_next = sum_a;
              end else if (s2.instr.use_b && !s2.instr.use_c) begin
                acc_next = sum_a;
                wen      = 1'b1;
                waddr    = s2.instr.addr_b[DATA_AW-1:0];
                wdata    = mb + sum_a;
              end else if (s2.instr.use_b && s2.instr.use_c) begin
                acc_next = sum_ab;
                wen      = 1'b1;
                waddr    = s2.instr.addr_c[DATA_AW-1:0];
                wdata    = sum_ab;
              end
            end
            OP_INC: begin
              wen   = 1'b1;
              wdata = ma + WORD_W'(1);
            end
            OP_DEC: begin
              wen   = 1'b1;
              wdata = ma - WORD_W'(1);
            end
            OP_STR: begin
              wen   = 1'b1;
              wdata = acc;
            end
            OP_SHW: begin
              shown       = 1'b1;
              shown_value = s2.instr.show_acc ? acc : ma;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* rtl/accumulator_machine_step_core.sv */
// Top level of the accumulator machine.
//
// Requests: drive request and raise start; a request is taken at each rising
// edge where start is high and busy is low. busy is high only during reset,
// so one request can be taken every cycle.
// Each request gives exactly one result: done is high for one cycle with the
// result on result, once the request has passed the request register, the
// execute register and the result register. The receiver cannot hold results
// off; none is needed, as results leave at the same rate requests enter.
// The core has two stages: the fetch stage reads the prefetched slot of
// the instruction store, and the execute stage works on operands from the
// registered reads of the data store (two read copies, one write port), with
// forwarding of the word written in the cycle before.
// program_length is written through cfg_valid/cfg_ready/cfg_data; cfg_ready
// is always high. Write it only while no request is in flight.
// Reset (synchronous, active high) clears the accumulator, counter,
// program_length and the valid bit of every data word, so the data store
// reads as zero at once; no clearing pass. Instruction slots are undefined
// until written.
module accumulator_machine_step_core import ams_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  in_item_t         request,
  output logic             done,
  output out_item_t        result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data
);

`include "accumulator_machine_step_core_defines.svh"

  logic             accept;
  logic [CNT_W-1:0] prog_len;
  exec_ctl_t        ctl;

  assign busy      = rst;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // program length register
  always_ff @(posedge clk) begin
    if (rst) begin
      prog_len <= '0;
    end else if (cfg_valid && cfg_ready) begin
      prog_len <= cfg_data;
    end
  end

  ams_fetch u_fetch (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .request  (request),
    .prog_len (prog_len),
    .ctl      (ctl)
  );

  ams_exec u_exec (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .done   (done),
    .result (result)
  );

  // every request gives a result, and every result comes from a request
  `AMS_ASSERT_LAT3(a_req_to_done, accept, done)
  `AMS_ASSERT_IMPLIES(a_done_from_req, done, $past(accept, 3))
  // a taken step leaves the counter within the loaded program
  `AMS_ASSERT_IMPLIES(a_pc_bound, done && result.step_taken,
                      (result.program_counter != '0) && (result.program_counter <= prog_len))

endmodule

/* test/accumulator_machine_step_core_tb.sv */
// Testbench of the accumulator machine: shadow machine, result checker and request driver.
`timescale 1ns / 100ps

import ams_pkg::*;

// Shadow copy of the machine; predicts one result per request and checks it.
class machine_shadow;
  logic [WORD_W-1:0] acc;
  logic [CNT_W-1:0]  counter;
  logic [CNT_W-1:0]  prog_len;
  logic [WORD_W-1:0] data_mem [DATA_WORDS];
  instr_t            slot_mem [PROG_WORDS];
  bit                slot_written [PROG_WORDS];
  out_item_t         step_outputs [$];
  int                errors;

  function new();
    acc      = '0;
    counter  = '0;
    prog_len = '0;
    errors   = 0;
    foreach (data_mem[i]) data_mem[i] = '0;
    foreach (slot_written[i]) slot_written[i] = 1'b0;
  endfunction

  function void set_length(logic [CNT_W-1:0] len);
    prog_len = len;
  endfunction

  function int pending();
    return step_outputs.size();
  endfunction

  // apply one accepted request and queue the result it must produce
  function void take_request(in_item_t rq);
    out_item_t         o;
    instr_t            ins;
    logic [WORD_W-1:0] ma;
    o = '0;
    case (action_t'(rq.action))
      ACT_DATA: data_mem[rq.addr_a] = rq.data_value;
      ACT_INSTR: begin
        ins.opcode   = rq.opcode;
        ins.addr_a   = rq.addr_a;
        ins.addr_b   = rq.addr_b;
        ins.addr_c   = rq.addr_c;
        ins.use_b    = rq.use_b;
        ins.use_c    = rq.use_c;
        ins.show_acc = rq.show_acc;
        slot_mem[rq.slot]     = ins;
        slot_written[rq.slot] = 1'b1;
      end
      ACT_STEP: begin
        if (counter < prog_len) begin
          ins          = slot_mem[counter[PROG_AW-1:0]];
          counter      = counter + 1'b1;
          o.step_taken = 1'b1;
          ma           = data_mem[ins.addr_a];
          case (ins.opcode)
            OP_LDR: acc = ma;
            OP_ADD: begin
              if (!ins.use_b && !ins.use_c) begin
                acc = acc + ma;
              end else if (ins.use_b && !ins.use_c) begin
                acc = acc + ma;
                data_mem[ins.addr_b] = data_mem[ins.addr_b] + acc;
              end else if (ins.use_b && ins.use_c) begin
                acc = acc + ma + data_mem[ins.addr_b];
                data_mem[ins.addr_c] = acc;
              end
              // use_c without use_b: the step counts, nothing else
            end
            OP_INC: data_mem[ins.addr_a] = ma + 1'b1;
            OP_DEC: data_mem[ins.addr_a] = ma - 1'b1;
            OP_STR: data_mem[ins.addr_a] = acc;
            OP_SHW: begin
              o.shown       = 1'b1;
              o.shown_value = ins.show_acc ? acc : ma;
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
    o.accumulator_value = acc;
    o.program_counter   = counter;
    step_outputs.insert(step_outputs.size(), o);
  endfunction

  function void check_field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %h, actual %h", name, want, got);
      errors++;
    end
  endfunction

  // compare a result with the oldest prediction
  function void match_result(out_item_t got);
    out_item_t want;
    if (step_outputs.size() == 0) begin
      $error("result with no request pending: %h", got);
      errors++;
      return;
    end
    want = step_outputs.pop_front();
    check_field("shown", WORD_W'(want.shown), WORD_W'(got.shown));
    check_field("shown_value", want.shown_value, got.shown_value);
    check_field("accumulator_value", want.accumulator_value, got.accumulator_value);
    check_field("program_counter", WORD_W'(want.program_counter),
                WORD_W'(got.program_counter));
    check_field("step_taken", WORD_W'(want.step_taken), WORD_W'(got.step_taken));
  endfunction
endclass

module accumulator_machine_step_core_tb;

  localparam logic [2:0] OP_NOP6 = 3'd6;
  localparam logic [2:0] OP_NOP7 = 3'd7;
  localparam int         STALL_LIMIT = 2000;
  localparam int         NUM_PHASES = 7;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  in_item_t         request = '0;
  logic             done;
  out_item_t        result;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data = '0;

  machine_shadow sh = new();
  int            idle_cycles = 0;

  accumulator_machine_step_core DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // results are sampled on the edge that ends their cycle
  always @(posedge clk) begin
    if (!rst && done) sh.match_result(result);
  end

  // watchdog: too many cycles without any handshake
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // addresses cluster on a few words so instructions feed each other
  function automatic logic [ADDR_W-1:0] pick_addr();
    if ($urandom_range(0, 9) < 7) return ADDR_W'($urandom_range(0, 7));
    return ADDR_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 32'd1;
      2: return '1;
      3: return 32'h7fff_ffff;
      4: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // every field random; callers overwrite what matters
  function automatic in_item_t noise_item(action_t act);
    in_item_t it;
    it.action     = act;
    it.slot       = ADDR_W'($urandom_range(0, 255));
    it.opcode     = 3'($urandom_range(0, 7));
    it.addr_a     = pick_addr();
    it.addr_b     = pick_addr();
    it.addr_c     = pick_addr();
    it.use_b      = 1'($urandom_range(0, 1));
    it.use_c      = 1'($urandom_range(0, 1));
    it.show_acc   = 1'($urandom_range(0, 1));
    it.data_value = pick_word();
    return it;
  endfunction

  function automatic in_item_t data_item(logic [ADDR_W-1:0] a, logic [WORD_W-1:0] v);
    in_item_t it;
    it            = noise_item(ACT_DATA);
    it.addr_a     = a;
    it.data_value = v;
    return it;
  endfunction

  function automatic in_item_t instr_item(logic [ADDR_W-1:0] s, logic [2:0] op,
                                          logic [ADDR_W-1:0] a, logic [ADDR_W-1:0] b,
                                          logic [ADDR_W-1:0] c, logic ub, logic uc,
                                          logic sa);
    in_item_t it;
    it          = noise_item(ACT_INSTR);
    it.slot     = s;
    it.opcode   = op;
    it.addr_a   = a;
    it.addr_b   = b;
    it.addr_c   = c;
    it.use_b    = ub;
    it.use_c    = uc;
    it.show_acc = sa;
    return it;
  endfunction

  // random request; a step onto an unwritten slot becomes a write of that slot
  function automatic in_item_t random_item();
    in_item_t    it;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 40)      it = noise_item(ACT_STEP);
    else if (roll < 68) it = noise_item(ACT_DATA);
    else if (roll < 96) it = noise_item(ACT_INSTR);
    else                it = noise_item(ACT_NONE);
    if (it.action == ACT_INSTR && $urandom_range(0, 1))
      it.slot = ADDR_W'(sh.counter[PROG_AW-1:0] + $urandom_range(0, 4));
    if (it.action == ACT_STEP && sh.counter < sh.prog_len &&
        !sh.slot_written[sh.counter[PROG_AW-1:0]]) begin
      it.action = ACT_INSTR;
      it.slot   = sh.counter[PROG_AW-1:0];
    end
    return it;
  endfunction

  // present one request and wait until it is taken
  task automatic send(in_item_t it);
    request <= it;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    sh.take_request(it);
  endtask

  // stop sending and wait for every pending result
  task automatic drain();
    start <= 1'b0;
    while (sh.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_program_length(logic [CNT_W-1:0] len);
    cfg_data  <= len;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sh.set_length(len);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int unsigned phase_len [NUM_PHASES];
    int          n_items;

    phase_len = '{0, 40, 80, 120, 170, 220, 256};
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: step past end with zero length, ignored action
    set_program_length(0);
    send(noise_item(ACT_STEP));
    send(noise_item(ACT_NONE));

    // extreme data words
    send(data_item(8'd0, 32'h7fff_ffff));
    send(data_item(8'd255, 32'h8000_0000));
    send(data_item(8'd1, 32'hffff_ffff));

    // a short program covering every opcode and ADD form
    send(instr_item(8'd0, OP_LDR, 8'd0, 8'd9, 8'd9, 1'b0, 1'b0, 1'b0));
    send(instr_item(8'd1, OP_ADD, 8'd1, 8'd9, 8'd9, 1'b0, 1'b0, 1'b0));
    send(instr_item(8'd2, OP_ADD, 8'd255, 8'd2, 8'd9, 1'b1, 1'b0, 1'b0));
    send(instr_item(8'd3, OP_ADD, 8'd0, 8'd1, 8'd3, 1'b1, 1'b1, 1'b0));
    send(instr_item(8'd4, OP_ADD, 8'd0, 8'd1, 8'd2, 1'b0, 1'b1, 1'b0));
    send(instr_item(8'd5, OP_INC, 8'd255, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0));
    send(instr_item(8'd6, OP_DEC, 8'd4, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0));
    send(instr_item(8'd7, OP_STR, 8'd5, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0));
    send(instr_item(8'd8, OP_SHW, 8'd5, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0));
    send(instr_item(8'd9, OP_SHW, 8'd255, 8'd0, 8'd0, 1'b1, 1'b1, 1'b1));
    send(instr_item(8'd10, OP_NOP6, 8'd255, 8'd255, 8'd255, 1'b1, 1'b1, 1'b1));
    send(instr_item(8'd11, OP_NOP7, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0));
    send(instr_item(8'd12, OP_ADD, 8'd3, 8'd3, 8'd3, 1'b1, 1'b1, 1'b0));
    send(instr_item(8'd255, OP_NOP7, 8'd255, 8'd255, 8'd255, 1'b1, 1'b1, 1'b1));
    drain();
    set_program_length(13);
    repeat (13) send(noise_item(ACT_STEP));

    // random phases with a growing program length; no idling in the last one
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      set_program_length(CNT_W'(phase_len[p]));
      n_items = (phase_len[p] == 0) ? 100 : 230;
      for (int k = 0; k < n_items; k++) begin
        if (p < NUM_PHASES - 1 && $urandom_range(0, 99) < 15) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        send(random_item());
      end
    end

    drain();
    repeat (6) @(posedge clk);
    if (sh.pending() != 0) $error("%0d results never arrived", sh.pending());
    if (sh.errors == 0 && sh.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/ams_pkg.sv
rtl/ams_ram.sv
rtl/ams_fetch.sv
rtl/ams_exec.sv
rtl/accumulator_machine_step_core.sv
test/accumulator_machine_step_core_tb.sv
